// ----- hdl/cats_pkg.sv -----
`default_nettype none

package cats_pkg;

  // Field widths
  localparam int TIME_W    = 32;
  localparam int SNR_W     = 10;
  localparam int BYTES_W   = 32;
  localparam int SEQ_W     = 32;
  localparam int ALPHA_W   = 4;
  localparam int MAX_W     = 6;
  localparam int CHUNK_W   = 20;
  localparam int SECONDS_W = 12;
  localparam int SEED_W    = 32;

  // Denominator 10 * metric_max, at most 630
  localparam int DEN_W = 10;

  // LFSR and draw
  localparam int                  LFSR_W    = 32;
  localparam int                  DRAW_W    = 16;
  localparam logic [LFSR_W-1:0]   LFSR_MASK = 32'h8020_0003;

  localparam int FRACTION_BITS_DEFAULT = 16;

  // Configuration port
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_ALPHA        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_UL_MAX       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DL_MAX       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CHUNK        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SEED         = 3'd6;

  // Register reset values
  localparam logic [ALPHA_W-1:0]   ALPHA_RST        = 4'd6;
  localparam logic [MAX_W-1:0]     METRIC_MAX_RST   = 6'd30;
  localparam logic [CHUNK_W-1:0]   CHUNK_RST        = 20'd52429;
  localparam logic [SECONDS_W-1:0] TIMEOUT_RST      = 12'd120;
  localparam logic [SECONDS_W-1:0] MIN_INTERVAL_RST = 12'd10;
  localparam logic [SEED_W-1:0]    SEED_RST         = 32'd1;

endpackage

`default_nettype wire

// ----- hdl/cats_if.sv -----
`default_nettype none

interface cats_sample_if;
  import cats_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        time_seconds;
  logic signed [SNR_W-1:0]  snr_tenths_db;

  modport source (output valid, output time_seconds, output snr_tenths_db, input ready);
  modport sink   (input valid, input time_seconds, input snr_tenths_db, output ready);
endinterface

interface cats_decision_if;
  import cats_pkg::*;

  logic               valid;
  logic               ready;
  logic               uplink_send;
  logic [BYTES_W-1:0] uplink_bytes;
  logic [SEQ_W-1:0]   uplink_sequence;
  logic               downlink_send;
  logic [BYTES_W-1:0] downlink_bytes;
  logic [SEQ_W-1:0]   downlink_sequence;

  modport source (
    output valid, input ready,
    output uplink_send, output uplink_bytes, output uplink_sequence,
    output downlink_send, output downlink_bytes, output downlink_sequence
  );
  modport sink (
    input valid, output ready,
    input uplink_send, input uplink_bytes, input uplink_sequence,
    input downlink_send, input downlink_bytes, input downlink_sequence
  );
endinterface

`default_nettype wire

// ----- hdl/channel_aware_transmit_scheduler.sv -----
// Per direction, the restoring divider (one bit a cycle) and up to alpha-1 passes
// through the shared multiplier set the time from sample accept to decision valid.
// Throughput: one sample in flight; the next is taken the cycle after the decision is
// registered, and a decision still waiting for ready holds the sequencer in its finish state.
// Reset: synchronous rst clears buffers, counters, last-send times and loads the
// register defaults, with the LFSR loaded from the default seed.
`default_nettype none

module channel_aware_transmit_scheduler #(
  parameter int FRACTION_BITS = cats_pkg::FRACTION_BITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  cats_sample_if.sink                      sample,
  cats_decision_if.source                  decision,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cats_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cats_pkg::DATA_W-1:0] pwdata,
  output logic      [cats_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import cats_pkg::*;

  localparam int FB     = FRACTION_BITS;
  // Dividend |snr| << FB, quotient has the same width
  localparam int NW     = FB + SNR_W;
  localparam int DCNT_W = $clog2(NW);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DELTA,
    ST_CHECK,
    ST_DRAW,
    ST_DIV,
    ST_EVAL,
    ST_MUL,
    ST_CMP,
    ST_COMMIT,
    ST_FINISH
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ALPHA_W-1:0]   alpha;
  logic [MAX_W-1:0]     ul_max;
  logic [MAX_W-1:0]     dl_max;
  logic [CHUNK_W-1:0]   chunk_bytes;
  logic [SECONDS_W-1:0] timeout_seconds;
  logic [SECONDS_W-1:0] min_interval_seconds;
  logic [SEED_W-1:0]    random_seed;

  logic                 cfg_write;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha                <= ALPHA_RST;
      ul_max               <= METRIC_MAX_RST;
      dl_max               <= METRIC_MAX_RST;
      chunk_bytes          <= CHUNK_RST;
      timeout_seconds      <= TIMEOUT_RST;
      min_interval_seconds <= MIN_INTERVAL_RST;
      random_seed          <= SEED_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_ALPHA:        alpha                <= pwdata[ALPHA_W-1:0];
        REG_UL_MAX:       ul_max               <= pwdata[MAX_W-1:0];
        REG_DL_MAX:       dl_max               <= pwdata[MAX_W-1:0];
        REG_CHUNK:        chunk_bytes          <= pwdata[CHUNK_W-1:0];
        REG_TIMEOUT:      timeout_seconds      <= pwdata[SECONDS_W-1:0];
        REG_MIN_INTERVAL: min_interval_seconds <= pwdata[SECONDS_W-1:0];
        REG_SEED:         random_seed          <= pwdata[SEED_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ALPHA:        prdata = DATA_W'(alpha);
      REG_UL_MAX:       prdata = DATA_W'(ul_max);
      REG_DL_MAX:       prdata = DATA_W'(dl_max);
      REG_CHUNK:        prdata = DATA_W'(chunk_bytes);
      REG_TIMEOUT:      prdata = DATA_W'(timeout_seconds);
      REG_MIN_INTERVAL: prdata = DATA_W'(min_interval_seconds);
      REG_SEED:         prdata = DATA_W'(random_seed);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  state_t                  state;
  logic                    dir;          // 0: uplink, 1: downlink
  logic [TIME_W-1:0]       now;
  logic signed [SNR_W-1:0] snr;
  logic [TIME_W-1:0]       delta;
  logic                    send_flag;
  logic [LFSR_W-1:0]       lfsr;
  logic [DRAW_W-1:0]       draw;

  // Per-direction state, indexed by dir
  logic [TIME_W-1:0]       last_time [2];
  logic [BYTES_W-1:0]      buffer    [2];
  logic [SEQ_W-1:0]        count     [2];

  // Shared divider / multiplier registers
  logic [NW-1:0]           num;          // dividend in, quotient out
  logic [DEN_W-1:0]        rem;
  logic [DEN_W-1:0]        den;
  logic [DCNT_W-1:0]       dcnt;
  logic [FB-1:0]           prob;
  logic [ALPHA_W-1:0]      mcnt;

  // Decision under construction and its output register
  logic                    res_send  [2];
  logic [BYTES_W-1:0]      res_bytes [2];
  logic [SEQ_W-1:0]        res_seq   [2];
  logic                    out_valid;
  logic                    out_ul_send;
  logic [BYTES_W-1:0]      out_ul_bytes;
  logic [SEQ_W-1:0]        out_ul_seq;
  logic                    out_dl_send;
  logic [BYTES_W-1:0]      out_dl_bytes;
  logic [SEQ_W-1:0]        out_dl_seq;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0]       delta_next;
  logic [BYTES_W:0]        ul_sum;
  logic [BYTES_W:0]        dl_sum;
  logic [SNR_W-1:0]        mag;
  logic                    snr_neg;
  logic [MAX_W-1:0]        max_sel;
  logic [DEN_W-1:0]        den_next;
  logic [LFSR_W-1:0]       lfsr_next;
  logic [DEN_W:0]          rem_sh;
  logic                    rem_ge;
  logic [DEN_W:0]          rem_diff;
  logic                    q_big;
  logic [2*FB-1:0]         prod;
  logic [DRAW_W+FB-1:0]    cmp_draw;
  logic [DRAW_W+FB-1:0]    cmp_prob;

  // Elapsed time is the absolute difference, either order
  assign delta_next = (now >= last_time[dir]) ? (now - last_time[dir])
                                              : (last_time[dir] - now);

  // Saturating buffer add
  assign ul_sum = {1'b0, buffer[0]} + (BYTES_W+1)'(chunk_bytes);
  assign dl_sum = {1'b0, buffer[1]} + (BYTES_W+1)'(chunk_bytes);

  assign snr_neg = snr[SNR_W-1];
  // -512 maps to 512, which still fits unsigned
  assign mag     = snr_neg ? SNR_W'(-snr) : SNR_W'(snr);

  // Denominator 10 * max, a max of zero acts as one
  assign max_sel  = dir ? dl_max : ul_max;
  assign den_next = (max_sel == '0) ? DEN_W'(10)
                  : ((DEN_W'(max_sel) << 3) + (DEN_W'(max_sel) << 1));

  // Right-shifting Galois step
  assign lfsr_next = (lfsr >> 1) ^ (lfsr[0] ? LFSR_MASK : '0);

  // One restoring-division step
  assign rem_sh   = {rem, num[NW-1]};
  assign rem_ge   = rem_sh >= {1'b0, den};
  assign rem_diff = rem_sh - {1'b0, den};

  // Quotient of one or more gives p >= 1
  assign q_big = |num[NW-1:FB];

  assign prod = prob * num[FB-1:0];

  // draw / 2^16 < prob / 2^FB
  assign cmp_draw = {draw, {FB{1'b0}}};
  assign cmp_prob = {prob, {DRAW_W{1'b0}}};

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      dir          <= 1'b0;
      send_flag    <= 1'b0;
      lfsr         <= SEED_RST;
      out_valid    <= 1'b0;
      last_time[0] <= '0;
      last_time[1] <= '0;
      buffer[0]    <= '0;
      buffer[1]    <= '0;
      count[0]     <= '0;
      count[1]     <= '0;
      res_send[0]  <= 1'b0;
      res_send[1]  <= 1'b0;
    end else begin
      // Drop the decision once taken; the finish state reloads it on its own
      if (out_valid && decision.ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            now          <= sample.time_seconds;
            snr          <= sample.snr_tenths_db;
            res_send[0]  <= 1'b0;
            res_send[1]  <= 1'b0;
            res_bytes[0] <= '0;
            res_bytes[1] <= '0;
            res_seq[0]   <= '0;
            res_seq[1]   <= '0;
            state        <= ST_ACCUM;
          end
        end

        ST_ACCUM: begin
          buffer[0] <= ul_sum[BYTES_W] ? '1 : ul_sum[BYTES_W-1:0];
          buffer[1] <= dl_sum[BYTES_W] ? '1 : dl_sum[BYTES_W-1:0];
          dir       <= 1'b0;
          state     <= ST_DELTA;
        end

        ST_DELTA: begin
          delta <= delta_next;
          state <= ST_CHECK;
        end

        ST_CHECK: begin
          if (delta > TIME_W'(timeout_seconds)) begin
            send_flag <= 1'b1;
            state     <= ST_COMMIT;
          end else if (delta >= TIME_W'(min_interval_seconds)) begin
            // Negative probability: no send and no draw
            if (snr_neg && alpha[0]) begin
              send_flag <= 1'b0;
              state     <= ST_COMMIT;
            end else begin
              state <= ST_DRAW;
            end
          end else begin
            send_flag <= 1'b0;
            state     <= ST_COMMIT;
          end
        end

        ST_DRAW: begin
          lfsr <= lfsr_next;
          draw <= lfsr_next[LFSR_W-1:LFSR_W-DRAW_W];
          if (alpha == '0) begin
            send_flag <= 1'b1;
            state     <= ST_COMMIT;
          end else begin
            num   <= {mag, {FB{1'b0}}};
            rem   <= '0;
            den   <= den_next;
            dcnt  <= DCNT_W'(NW - 1);
            state <= ST_DIV;
          end
        end

        ST_DIV: begin
          rem <= rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          num <= {num[NW-2:0], rem_ge};
          if (dcnt == '0) begin
            state <= ST_EVAL;
          end else begin
            dcnt <= dcnt - 1'b1;
          end
        end

        ST_EVAL: begin
          if (q_big) begin
            send_flag <= 1'b1;
            state     <= ST_COMMIT;
          end else begin
            prob  <= num[FB-1:0];
            mcnt  <= ALPHA_W'(1);
            state <= (alpha == ALPHA_W'(1)) ? ST_CMP : ST_MUL;
          end
        end

        ST_MUL: begin
          // Truncating Q0.FB product, one per cycle
          prob <= prod[2*FB-1:FB];
          mcnt <= mcnt + 1'b1;
          if (mcnt + 1'b1 == alpha) begin
            state <= ST_CMP;
          end
        end

        ST_CMP: begin
          send_flag <= cmp_draw < cmp_prob;
          state     <= ST_COMMIT;
        end

        ST_COMMIT: begin
          if (send_flag) begin
            res_send[dir]  <= 1'b1;
            res_bytes[dir] <= buffer[dir];
            res_seq[dir]   <= count[dir];
            buffer[dir]    <= '0;
            count[dir]     <= count[dir] + 1'b1;
            last_time[dir] <= now;
          end
          if (!dir) begin
            dir   <= 1'b1;
            state <= ST_DELTA;
          end else begin
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          // Hold until the output register is free
          if (!out_valid || decision.ready) begin
            out_valid    <= 1'b1;
            out_ul_send  <= res_send[0];
            out_ul_bytes <= res_bytes[0];
            out_ul_seq   <= res_seq[0];
            out_dl_send  <= res_send[1];
            out_dl_bytes <= res_bytes[1];
            out_dl_seq   <= res_seq[1];
            state        <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase

      // Seed write loads the LFSR at once; a zero seed loads one
      if (cfg_write && cfg_idx == REG_SEED) begin
        lfsr <= (pwdata[SEED_W-1:0] != '0) ? pwdata[SEED_W-1:0] : LFSR_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Channel ports
  // ---------------------------------------------------------------------------
  assign sample.ready = (state == ST_IDLE);

  assign decision.valid             = out_valid;
  assign decision.uplink_send       = out_ul_send;
  assign decision.uplink_bytes      = out_ul_bytes;
  assign decision.uplink_sequence   = out_ul_seq;
  assign decision.downlink_send     = out_dl_send;
  assign decision.downlink_bytes    = out_dl_bytes;
  assign decision.downlink_sequence = out_dl_seq;

endmodule

`default_nettype wire

// ----- sim/channel_aware_transmit_scheduler_test.sv -----
`default_nettype none

module channel_aware_transmit_scheduler_test;
  import cats_pkg::*;

  localparam int FRAC = FRACTION_BITS_DEFAULT;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PRINT_LIMIT = 40;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic               ul_send;
    logic [BYTES_W-1:0] ul_bytes;
    logic [SEQ_W-1:0]   ul_seq;
    logic               dl_send;
    logic [BYTES_W-1:0] dl_bytes;
    logic [SEQ_W-1:0]   dl_seq;
  } decision_t;

  typedef struct {
    bit                      is_write;
    logic [REG_IDX_W-1:0]    idx;
    logic [DATA_W-1:0]       value;
    logic [TIME_W-1:0]       now;
    logic signed [SNR_W-1:0] snr;
    bit                      typed;
    decision_t               want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  cats_sample_if   sample_bus ();
  cats_decision_if decision_bus ();

  channel_aware_transmit_scheduler #(
    .FRACTION_BITS(FRAC)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_bus),
    .decision(decision_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Scheduler mirror: configuration and state
  logic [ALPHA_W-1:0]   cfg_alpha;
  logic [MAX_W-1:0]     cfg_ul_max;
  logic [MAX_W-1:0]     cfg_dl_max;
  logic [CHUNK_W-1:0]   cfg_chunk;
  logic [SECONDS_W-1:0] cfg_timeout;
  logic [SECONDS_W-1:0] cfg_min_gap;
  logic [SEED_W-1:0]    cfg_seed;

  logic [TIME_W-1:0]  ul_last, dl_last;
  logic [BYTES_W-1:0] ul_buf, dl_buf;
  logic [SEQ_W-1:0]   ul_count, dl_count;
  logic [LFSR_W-1:0]  lfsr_state;

  decision_t pending_decisions[$];
  stim_row_t directed_rows[$];
  int        error_count;
  int        decision_count;
  int        cycle_count;
  bit        steady_flow;

  // Clock and cycle watchdog
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch %s at decision %0d: got %0h want %0h",
               what, decision_count, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] register_mask(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_ALPHA:        return 32'h0000_000F;
      REG_UL_MAX:       return 32'h0000_003F;
      REG_DL_MAX:       return 32'h0000_003F;
      REG_CHUNK:        return 32'h000F_FFFF;
      REG_TIMEOUT:      return 32'h0000_0FFF;
      REG_MIN_INTERVAL: return 32'h0000_0FFF;
      REG_SEED:         return 32'hFFFF_FFFF;
      default:          return 32'h0;
    endcase
  endfunction

  function automatic void reset_scheduler_mirror();
    cfg_alpha   = ALPHA_RST;
    cfg_ul_max  = METRIC_MAX_RST;
    cfg_dl_max  = METRIC_MAX_RST;
    cfg_chunk   = CHUNK_RST;
    cfg_timeout = TIMEOUT_RST;
    cfg_min_gap = MIN_INTERVAL_RST;
    cfg_seed    = SEED_RST;
    ul_last = '0;
    dl_last = '0;
    ul_buf = '0;
    dl_buf = '0;
    ul_count = '0;
    dl_count = '0;
    lfsr_state = SEED_RST;
  endfunction

  function automatic void apply_register(input logic [REG_IDX_W-1:0] idx,
                                         input logic [DATA_W-1:0] value);
    case (idx)
      REG_ALPHA:        cfg_alpha = value[ALPHA_W-1:0];
      REG_UL_MAX:       cfg_ul_max = value[MAX_W-1:0];
      REG_DL_MAX:       cfg_dl_max = value[MAX_W-1:0];
      REG_CHUNK:        cfg_chunk = value[CHUNK_W-1:0];
      REG_TIMEOUT:      cfg_timeout = value[SECONDS_W-1:0];
      REG_MIN_INTERVAL: cfg_min_gap = value[SECONDS_W-1:0];
      REG_SEED: begin
        cfg_seed = value;
        // a zero seed would lock the LFSR, so load one instead
        lfsr_state = (value != 0) ? value : 32'd1;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] register_value(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_ALPHA:        return 32'(cfg_alpha);
      REG_UL_MAX:       return 32'(cfg_ul_max);
      REG_DL_MAX:       return 32'(cfg_dl_max);
      REG_CHUNK:        return 32'(cfg_chunk);
      REG_TIMEOUT:      return 32'(cfg_timeout);
      REG_MIN_INTERVAL: return 32'(cfg_min_gap);
      REG_SEED:         return cfg_seed;
      default:          return 32'h0;
    endcase
  endfunction

  // Advance the Galois LFSR one step and take the top bits as the draw.
  function automatic logic [DRAW_W-1:0] next_draw();
    logic lsb;
    lsb = lfsr_state[0];
    lfsr_state = lfsr_state >> 1;
    if (lsb)
      lfsr_state = lfsr_state ^ LFSR_MASK;
    return lfsr_state[LFSR_W-1 -: DRAW_W];
  endfunction

  function automatic bit chance_send(input logic signed [SNR_W-1:0] snr,
                                     input logic [MAX_W-1:0] max_db);
    int          s;
    int          i;
    logic [63:0] mag, den, q, p, r, one;
    s = snr;
    one = 64'd1 << FRAC;
    mag = (s < 0) ? 64'(-s) : 64'(s);
    den = 64'd10 * ((max_db == 0) ? 64'd1 : 64'(max_db));
    q = (mag << FRAC) / den;
    // negative ratio raised to an odd power: no send and no draw
    if (s < 0 && cfg_alpha[0])
      return 1'b0;
    r = 64'(next_draw());
    if (cfg_alpha == 0 || q >= one)
      return 1'b1;
    p = q;
    for (i = 1; i < int'(cfg_alpha); i++)
      p = (p * q) >> FRAC;
    return (r << FRAC) < (p << DRAW_W);
  endfunction

  function automatic bit decide_send(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] last,
                                     input logic signed [SNR_W-1:0] snr,
                                     input logic [MAX_W-1:0] max_db);
    logic [TIME_W-1:0] delta;
    delta = (now >= last) ? now - last : last - now;
    if (delta > 32'(cfg_timeout))
      return 1'b1;
    if (delta >= 32'(cfg_min_gap))
      return chance_send(snr, max_db);
    return 1'b0;
  endfunction

  function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                 input logic [BYTES_W-1:0] b);
    logic [BYTES_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
  endfunction

  function automatic decision_t predict_decision(input logic [TIME_W-1:0] now,
                                                 input logic signed [SNR_W-1:0] snr);
    decision_t d;
    d = '0;
    ul_buf = sat_add(ul_buf, 32'(cfg_chunk));
    dl_buf = sat_add(dl_buf, 32'(cfg_chunk));
    // uplink decides first, so it takes the first draw
    if (decide_send(now, ul_last, snr, cfg_ul_max)) begin
      d.ul_send = 1'b1;
      d.ul_bytes = ul_buf;
      d.ul_seq = ul_count;
      ul_buf = '0;
      ul_count++;
      ul_last = now;
    end
    if (decide_send(now, dl_last, snr, cfg_dl_max)) begin
      d.dl_send = 1'b1;
      d.dl_bytes = dl_buf;
      d.dl_seq = dl_count;
      dl_buf = '0;
      dl_count++;
      dl_last = now;
    end
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  task automatic apb_access(input bit wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, mirror it, and read it back where it exists.
  task automatic set_register(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rdata;
    apb_access(1'b1, idx, value, rdata);
    apply_register(idx, value);
    if (idx != REG_UNUSED) begin
      apb_access(1'b0, idx, '0, rdata);
      if ((rdata & register_mask(idx)) != register_value(idx))
        report_mismatch($sformatf("register %0d readback", idx),
                        rdata & register_mask(idx), register_value(idx));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sample side
  // ---------------------------------------------------------------------------
  // Enter at or after a posedge; leaves valid high after the accept so the next
  // item can follow back to back.
  task automatic push_sample(input logic [TIME_W-1:0] now, input logic signed [SNR_W-1:0] snr,
                             input bit typed, input decision_t typed_want);
    decision_t d;
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < 32) begin
      sample_bus.valid <= 1'b0;
      sample_bus.time_seconds <= $urandom;
      sample_bus.snr_tenths_db <= SNR_W'($urandom);
      @(negedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.time_seconds <= now;
    sample_bus.snr_tenths_db <= snr;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    d = predict_decision(now, snr);
    pending_decisions.push_back(typed ? typed_want : d);
  endtask

  task automatic hold_off_samples();
    @(negedge clk);
    sample_bus.valid <= 1'b0;
  endtask

  // Wait until every expected decision has come back.
  task automatic drain_decisions();
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic idle_and_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    hold_off_samples();
    drain_decisions();
    set_register(idx, value);
  endtask

  // ---------------------------------------------------------------------------
  // Decision side
  // ---------------------------------------------------------------------------
  initial begin
    decision_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      decision_bus.ready <= steady_flow || ($urandom_range(99) >= 32);
    end
  end

  initial begin
    decision_t want;
    forever begin
      @(posedge clk);
      if (!rst && decision_bus.valid && decision_bus.ready) begin
        if (pending_decisions.size() == 0) begin
          report_mismatch("decision with none expected", 32'(decision_bus.uplink_send), 0);
        end else begin
          want = pending_decisions.pop_front();
          if (decision_bus.uplink_send !== want.ul_send)
            report_mismatch("uplink_send", 32'(decision_bus.uplink_send), 32'(want.ul_send));
          if (decision_bus.uplink_bytes !== want.ul_bytes)
            report_mismatch("uplink_bytes", decision_bus.uplink_bytes, want.ul_bytes);
          if (decision_bus.uplink_sequence !== want.ul_seq)
            report_mismatch("uplink_sequence", decision_bus.uplink_sequence, want.ul_seq);
          if (decision_bus.downlink_send !== want.dl_send)
            report_mismatch("downlink_send", 32'(decision_bus.downlink_send), 32'(want.dl_send));
          if (decision_bus.downlink_bytes !== want.dl_bytes)
            report_mismatch("downlink_bytes", decision_bus.downlink_bytes, want.dl_bytes);
          if (decision_bus.downlink_sequence !== want.dl_seq)
            report_mismatch("downlink_sequence", decision_bus.downlink_sequence, want.dl_seq);
        end
        decision_count++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed rows
  // ---------------------------------------------------------------------------
  function automatic void add_write(input logic [REG_IDX_W-1:0] idx,
                                    input logic [DATA_W-1:0] value);
    stim_row_t row;
    row = '{is_write: 1'b1, idx: idx, value: value, now: '0, snr: '0, typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_sample(input logic [TIME_W-1:0] now,
                                     input logic signed [SNR_W-1:0] snr,
                                     input bit typed, input decision_t want);
    stim_row_t row;
    row = '{is_write: 1'b0, idx: '0, value: '0, now: now, snr: snr, typed: typed, want: want};
    directed_rows.push_back(row);
  endfunction

  function automatic decision_t both_sent(input logic [BYTES_W-1:0] bytes,
                                          input logic [SEQ_W-1:0] seq);
    decision_t d;
    d = '{ul_send: 1'b1, ul_bytes: bytes, ul_seq: seq,
          dl_send: 1'b1, dl_bytes: bytes, dl_seq: seq};
    return d;
  endfunction

  function automatic logic [31:0] pick_range(input logic [31:0] lo, input logic [31:0] hi);
    case ($urandom_range(7))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t         row;
    logic [TIME_W-1:0] now;
    logic [31:0]       timeout_pick;
    int                bias;
    int                phase;
    int                n;
    logic signed [SNR_W-1:0] snr;

    error_count = 0;
    decision_count = 0;
    steady_flow = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_bus.valid = 1'b0;
    sample_bus.time_seconds = '0;
    sample_bus.snr_tenths_db = '0;
    reset_scheduler_mirror();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // From reset: nothing sent, then a forced send on both, a reversed clock
    // and the largest timestamp; the typed rows follow from the defaults.
    add_sample(32'd0, 10'sd0, 1'b1, '0);
    add_sample(32'd121, 10'sd0, 1'b1, both_sent(32'd104858, 32'd0));
    add_sample(32'd121, 10'sd511, 1'b1, '0);
    add_sample(32'd0, -10'sd512, 1'b1, both_sent(32'd104858, 32'd1));
    add_sample(32'hFFFF_FFFF, 10'sd511, 1'b1, both_sent(32'd52429, 32'd2));
    add_sample(32'hFFFF_FFF5, 10'sd300, 1'b0, '0);
    add_sample(32'hFFFF_FFEA, -10'sd300, 1'b0, '0);
    // odd exponent with a negative ratio
    add_write(REG_ALPHA, 32'd1);
    add_sample(32'hFFFF_FFD0, -10'sd1, 1'b0, '0);
    add_sample(32'hFFFF_FF00, 10'sd511, 1'b0, '0);
    // largest exponent, largest and zero metric max
    add_write(REG_ALPHA, 32'd15);
    add_write(REG_UL_MAX, 32'd63);
    add_write(REG_DL_MAX, 32'd0);
    add_sample(32'hFFFF_FE00, 10'sd200, 1'b0, '0);
    add_sample(32'hFFFF_FD00, -10'sd512, 1'b0, '0);
    add_write(REG_ALPHA, 32'd0);
    add_sample(32'hFFFF_FC00, -10'sd100, 1'b0, '0);
    add_write(REG_CHUNK, 32'h000F_FFFF);
    add_write(REG_TIMEOUT, 32'd0);
    add_write(REG_MIN_INTERVAL, 32'd0);
    add_sample(32'hFFFF_FC00, 10'sd5, 1'b0, '0);
    add_sample(32'd5, 10'sd0, 1'b0, '0);
    // zero seed, all-ones seed, then the far ends of the time limits
    add_write(REG_SEED, 32'd0);
    add_sample(32'd5, 10'sd17, 1'b0, '0);
    add_write(REG_SEED, 32'hFFFF_FFFF);
    add_write(REG_CHUNK, 32'd0);
    add_write(REG_TIMEOUT, 32'd4095);
    add_write(REG_MIN_INTERVAL, 32'd4095);
    add_write(REG_ALPHA, 32'd2);
    add_write(REG_UNUSED, 32'hFFFF_FFFF);
    add_sample(32'd6, 10'sd250, 1'b0, '0);
    add_sample(32'd4102, -10'sd250, 1'b0, '0);
    add_sample(32'h8000_0000, 10'sd0, 1'b0, '0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_write)
        idle_and_write(row.idx, row.value);
      else
        push_sample(row.now, row.snr, row.typed, row.want);
    end

    // Random phases: every register rewritten, then a run of samples whose
    // timestamps mostly creep forward so both timers and draws get exercised.
    now = 32'h8000_0000;
    for (phase = 0; phase < 12; phase++) begin
      hold_off_samples();
      drain_decisions();
      steady_flow = (phase == 5);
      set_register(REG_ALPHA, pick_range(0, 15));
      set_register(REG_UL_MAX, pick_range(0, 63));
      set_register(REG_DL_MAX, pick_range(0, 63));
      case ($urandom_range(3))
        0:       set_register(REG_CHUNK, pick_range(0, 32'h000F_FFFF));
        default: set_register(REG_CHUNK, $urandom_range(100000));
      endcase
      case ($urandom_range(7))
        0:       timeout_pick = 0;
        1:       timeout_pick = 4095;
        default: timeout_pick = $urandom_range(200, 5);
      endcase
      set_register(REG_TIMEOUT, timeout_pick);
      case ($urandom_range(7))
        0:       set_register(REG_MIN_INTERVAL, 0);
        1:       set_register(REG_MIN_INTERVAL, 4095);
        default: set_register(REG_MIN_INTERVAL, $urandom_range(timeout_pick, 0));
      endcase
      case ($urandom_range(7))
        0:       set_register(REG_SEED, 32'd0);
        1:       set_register(REG_SEED, 32'hFFFF_FFFF);
        default: set_register(REG_SEED, $urandom);
      endcase

      for (n = 0; n < 150; n++) begin
        case ($urandom_range(15))
          0:       now = $urandom;
          1:       now = now - $urandom_range(int'(cfg_timeout) + 20);
          default: now = now + $urandom_range(int'(cfg_timeout) + 20);
        endcase
        if ($urandom_range(3) == 0) begin
          // land near the uplink full-scale point
          bias = int'(cfg_ul_max) * 10 - 20 + int'($urandom_range(40));
          if (bias > 511)
            bias = 511;
          if ($urandom_range(1))
            bias = -bias;
          snr = SNR_W'(bias);
        end else begin
          snr = SNR_W'($urandom_range(1023));
        end
        push_sample(now, snr, 1'b0, '0);
      end
    end
    steady_flow = 1'b0;

    hold_off_samples();
    drain_decisions();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
